[src/pcm_pkg.sv]
// Shared types and constants for the palette color match block.
// No dependencies; imported by every module of the block.
package pcm_pkg;

  // Channel and field widths
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 4 * CHAN_W;
  localparam int IDX_W      = 8;
  localparam int COUNT_W    = 9;
  localparam int DIST_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Reset values of the configuration registers
  localparam logic [COUNT_W-1:0] COLORS_IN_USE_RST = 9'd256;
  localparam logic               MATCH_MODE_RST    = 1'b0;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLORS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE    = 1'b1;

  // Function codes of an input item
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Match modes
  localparam logic MODE_EXACT   = 1'b0;
  localparam logic MODE_CLOSEST = 1'b1;

  // Command passed from front to back
  typedef struct packed {
    logic               is_search;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] color;     // alpha, blue, green, red from msb down
  } cmd_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [COUNT_W-1:0] colors_in_use;
    logic               match_mode;
  } cfg_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } pcm_state_t;

endpackage

[src/palette_color_match_unit.sv]
// Palette color match block, top level: configuration registers and wiring.
// Depends on pcm_pkg, pcm_front, pcm_queue and pcm_back.
//
// Items enter a four-deep command queue and are carried out one at a time by
// the back end, which owns a single-port palette memory. A palette write is
// taken in the back end's idle state and gives no result. A search reads one
// palette entry per cycle through that memory port and scans the first N
// entries, where N is colors_in_use saturated to PALETTE_SIZE; an exact hit
// stops the scan early, and a stalled result holds the back end in its done
// state until the previous result has been taken. The result sits in
// an output register, so the block keeps taking items into the queue while a
// result waits. Palette entries hold no reset value: search only entries that
// have been written. Write colors_in_use and match_mode only while idle.
module palette_color_match_unit
  import pcm_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [CHAN_W-1:0]     red,
  input  logic [CHAN_W-1:0]     green,
  input  logic [CHAN_W-1:0]     blue,
  input  logic [CHAN_W-1:0]     alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  found,
  output logic [IDX_W-1:0]      color_index
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.colors_in_use <= COLORS_IN_USE_RST;
      cfg.match_mode    <= MATCH_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLORS_IN_USE: cfg.colors_in_use <= cfg_data[COUNT_W-1:0];
        CFG_MATCH_MODE:    cfg.match_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pcm_front #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .entry_index(entry_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd)
  );

  pcm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head),
    .pop     (q_pop)
  );

  pcm_back #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .color_index(color_index)
  );

endmodule

[src/pcm_front.sv]
// Front end: accepts input items, classifies them and builds queue commands.
// Depends on pcm_pkg.
module pcm_front
  import pcm_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic [CHAN_W-1:0]  alpha,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic in_range;
  logic keep;

  // Drop writes that land beyond the palette
  assign in_range = (int'(entry_index) < PALETTE_SIZE);
  assign keep     = (func == FUNC_SEARCH) || in_range;

  // Hold the input while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

  // Pack the command
  always_comb begin
    q_cmd.is_search   = (func == FUNC_SEARCH);
    q_cmd.entry_index = entry_index;
    q_cmd.color       = {alpha, blue, green, red};
  end

endmodule

[src/pcm_queue.sv]
// Short command queue between the front and back ends.
// Depends on pcm_pkg.
module pcm_queue
  import pcm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

[src/pcm_back.sv]
// Back end: palette memory, scan sequencer, distance compare and result register.
// Depends on pcm_pkg.
module pcm_back
  import pcm_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic [IDX_W-1:0] color_index
);

  localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int CW = AW + 1;
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  pcm_state_t state;
  pcm_state_t state_next;

  // Palette memory, one port
  logic [COLOR_W-1:0] palette [PALETTE_SIZE];
  logic [AW-1:0]      mem_addr;
  logic [COLOR_W-1:0] mem_q;
  logic               mem_we;

  // Scan control
  logic [CW-1:0]      issue_idx;
  logic [CW-1:0]      lim;
  logic [LW-1:0]      cin_ext;
  logic [LW-1:0]      lim_full;
  logic [COLOR_W-1:0] color;
  logic               mode;
  logic               issue;
  logic               hit;
  logic               scan_end;
  logic               out_load;

  // Compare pipeline
  logic               s1_vld;
  logic [AW-1:0]      s1_idx;
  logic               s2_vld;
  logic [AW-1:0]      s2_idx;
  logic               s2_eq;
  logic [CHAN_W-1:0]  s2_diff [4];
  logic [DIST_W-1:0]  l1_sum;

  // Best so far
  logic               have;
  logic [AW-1:0]      best_idx;
  logic [DIST_W-1:0]  best_dist;

  // Saturate the entry count to the palette size
  assign cin_ext  = LW'(cfg.colors_in_use);
  assign lim_full = (cin_ext > LW'(PALETTE_SIZE)) ? LW'(PALETTE_SIZE) : cin_ext;

  assign hit    = s2_vld && s2_eq;
  assign l1_sum = DIST_W'(s2_diff[0]) + DIST_W'(s2_diff[1])
                + DIST_W'(s2_diff[2]) + DIST_W'(s2_diff[3]);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid && q_cmd.is_search) state_next = ST_SCAN;
      ST_SCAN: if (scan_end) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    issue    = 1'b0;
    scan_end = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop  = q_valid;
        mem_we = q_valid && !q_cmd.is_search;
      end
      ST_SCAN: begin
        issue    = (issue_idx < lim) && !hit;
        scan_end = hit || ((issue_idx >= lim) && !s1_vld && !s2_vld);
      end
      ST_DONE: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign mem_addr = mem_we ? AW'(q_cmd.entry_index) : issue_idx[AW-1:0];

  // Palette write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) palette[mem_addr] <= q_cmd.color;
    mem_q <= palette[mem_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      have      <= 1'b0;
      out_valid <= 1'b0;
      issue_idx <= '0;
    end else begin
      state  <= state_next;
      s1_vld <= issue;
      s2_vld <= s1_vld && !hit;
      // Start a search
      if (state == ST_IDLE && q_valid && q_cmd.is_search) begin
        issue_idx <= '0;
        have      <= 1'b0;
      end else if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
      // Take the candidate
      if (hit) begin
        have <= 1'b1;
      end else if (s2_vld && mode == MODE_CLOSEST && (!have || l1_sum < best_dist)) begin
        have <= 1'b1;
      end
      // Present or drop the result
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_cmd.is_search) begin
      color <= q_cmd.color;
      mode  <= cfg.match_mode;
      lim   <= lim_full[CW-1:0];
    end
    s1_idx <= issue_idx[AW-1:0];
    s2_idx <= s1_idx;
    s2_eq  <= (mem_q == color);
    for (int k = 0; k < 4; k++) begin
      s2_diff[k] <= (mem_q[k*CHAN_W +: CHAN_W] > color[k*CHAN_W +: CHAN_W])
                  ? mem_q[k*CHAN_W +: CHAN_W] - color[k*CHAN_W +: CHAN_W]
                  : color[k*CHAN_W +: CHAN_W] - mem_q[k*CHAN_W +: CHAN_W];
    end
    if (hit) begin
      best_idx <= s2_idx;
    end else if (s2_vld && mode == MODE_CLOSEST && (!have || l1_sum < best_dist)) begin
      best_idx  <= s2_idx;
      best_dist <= l1_sum;
    end
    if (out_load) begin
      found       <= have;
      color_index <= have ? IDX_W'(best_idx) : '0;
    end
  end

endmodule

[verif/palette_color_match_unit_tb.sv]
// Testbench for palette_color_match_unit: palette writes, exact and closest searches.
// Depends on pcm_pkg and the RTL of the block; checks results against its own predictor.
`timescale 1ns / 100ps

module palette_color_match_unit_tb;
  import pcm_pkg::*;

  localparam int PAL_DEPTH     = 256;
  localparam int RAND_ITEMS    = 1650;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 3_000_000;

  // One input item, color packed as {alpha, blue, green, red}
  typedef struct packed {
    logic               func;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } pcm_req_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } match_t;

  // Directed row: settings it runs under, the item, and a typed answer if any
  typedef struct {
    int       cnt;
    logic     mode;
    pcm_req_t req;
    bit       typed;
    match_t   want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  func;
  logic [IDX_W-1:0]      entry_index;
  logic [CHAN_W-1:0]     red;
  logic [CHAN_W-1:0]     green;
  logic [CHAN_W-1:0]     blue;
  logic [CHAN_W-1:0]     alpha;
  logic                  out_valid;
  logic                  out_stall;
  logic                  found;
  logic [IDX_W-1:0]      color_index;

  // Shadow of the block's state
  logic [COLOR_W-1:0] pal_copy [PAL_DEPTH];
  bit [PAL_DEPTH-1:0] pal_written = '0;
  int                 cfg_count = 256;
  logic               cfg_mode = MODE_EXACT;

  match_t   pending_matches [$];
  dir_row_t dir_rows [$];
  int       fail_cnt = 0;
  int       items_sent = 0;
  int       cycles = 0;
  int       rx_hold = 0;
  bit       tx_quiet = 1'b0;
  bit       rx_quiet = 1'b0;

  palette_color_match_unit #(.PALETTE_SIZE(PAL_DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .color_index (color_index)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // First entry equal to the color, else (closest mode) first with least L1 distance
  function automatic match_t nearest_entry(input logic [COLOR_W-1:0] color);
    match_t m;
    int n, i, k, d, best_d, ea, ca;
    m = '0;
    best_d = 0;
    n = (cfg_count > PAL_DEPTH) ? PAL_DEPTH : cfg_count;
    for (i = 0; i < n; i++) begin
      if (pal_copy[i] == color) begin
        m.hit = 1'b1;
        m.index = i[IDX_W-1:0];
        return m;
      end
      if (cfg_mode == MODE_CLOSEST) begin
        d = 0;
        for (k = 0; k < 4; k++) begin
          ea = pal_copy[i][CHAN_W*k +: CHAN_W];
          ca = color[CHAN_W*k +: CHAN_W];
          d += (ea > ca) ? ea - ca : ca - ea;
        end
        if (!m.hit || d < best_d) begin
          m.hit = 1'b1;
          best_d = d;
          m.index = i[IDX_W-1:0];
        end
      end
    end
    return m;
  endfunction

  // Channel values lean on the extremes so that duplicates and ties show up
  function automatic logic [CHAN_W-1:0] rand_chan();
    if ($urandom_range(0, 1) == 0)
      return CHAN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // Mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int tx_gap();
    int r;
    if (tx_quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(input int cnt, input logic mode, input logic f, input int idx,
                         input logic [COLOR_W-1:0] color, input bit typed,
                         input logic hit, input int cidx);
    dir_row_t row;
    row.cnt = cnt;
    row.mode = mode;
    row.req.func = f;
    row.req.idx = idx[IDX_W-1:0];
    row.req.color = color;
    row.typed = typed;
    row.want.hit = hit;
    row.want.index = cidx[IDX_W-1:0];
    dir_rows.push_back(row);
  endtask

  // Drive one item and hold it until the transfer; then update the shadow state
  task automatic send_req(input pcm_req_t req, input bit typed, input match_t want);
    int gap;
    gap = tx_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    func = req.func;
    entry_index = req.idx;
    {alpha, blue, green, red} = req.color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req.func == FUNC_WRITE) begin
      pal_copy[req.idx] = req.color;
      pal_written[req.idx] = 1'b1;
    end else begin
      pending_matches.push_back(typed ? want : nearest_entry(req.color));
    end
    items_sent++;
  endtask

  // Drain, let queued palette writes finish, then write both registers
  task automatic set_config(input int cnt, input logic mode);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_COLORS_IN_USE;
    cfg_data = cnt[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index = CFG_MATCH_MODE;
    cfg_data = {{(CFG_DATA_W-1){1'b0}}, mode};
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_count = cnt;
    cfg_mode = mode;
  endtask

  task automatic log_error(input string what, input match_t want, input match_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t: %s: expected found=%0b index=%0d, got found=%0b index=%0d",
               $time, what, want.hit, want.index, got.hit, got.index);
  endtask

  // Receiver stall: random bursts, mostly short, a few long
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall = 1'b1;
        rx_hold--;
      end else if (!rx_quiet && $urandom_range(0, 99) < 12) begin
        out_stall = 1'b1;
        rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest pending match
  always @(posedge clk) begin
    match_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.hit = found;
      got.index = color_index;
      if (pending_matches.size() == 0) begin
        log_error("result with no search pending", '0, got);
      end else begin
        want = pending_matches.pop_front();
        if (got.hit !== want.hit || got.index !== want.index)
          log_error("result mismatch", want, got);
      end
    end
  end

  initial begin
    pcm_req_t req;
    dir_row_t row;
    int       phase, cnt, n, n_items, rand_start, i, k, r;
    logic     mode;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_COLORS_IN_USE;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_WRITE;
    entry_index = '0;
    red = '0;
    green = '0;
    blue = '0;
    alpha = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: cnt, mode, func, index, {a,b,g,r}, typed, found, color_index
    add_row(4, MODE_EXACT,   FUNC_WRITE,    0, 32'h0000_0000, 0, 0, 0);
    add_row(4, MODE_EXACT,   FUNC_WRITE,    1, 32'hFFFF_FFFF, 0, 0, 0);
    add_row(4, MODE_EXACT,   FUNC_WRITE,    2, 32'h7856_3412, 0, 0, 0);
    add_row(4, MODE_EXACT,   FUNC_WRITE,    3, 32'hFFFF_FFFF, 0, 0, 0);
    add_row(4, MODE_EXACT,   FUNC_WRITE,  255, 32'h3CC3_5AA5, 0, 0, 0);
    add_row(4, MODE_EXACT,   FUNC_SEARCH, 255, 32'h0000_0000, 1, 1, 0);
    add_row(4, MODE_EXACT,   FUNC_SEARCH,   0, 32'hFFFF_FFFF, 1, 1, 1);
    add_row(4, MODE_EXACT,   FUNC_SEARCH, 255, 32'h7856_3412, 1, 1, 2);
    add_row(4, MODE_EXACT,   FUNC_SEARCH,   0, 32'h0000_0001, 1, 0, 0);
    add_row(4, MODE_EXACT,   FUNC_SEARCH,   0, 32'hFFFF_FFFE, 1, 0, 0);
    add_row(4, MODE_CLOSEST, FUNC_SEARCH,   0, 32'h0000_0001, 0, 0, 0);
    add_row(4, MODE_CLOSEST, FUNC_SEARCH,   0, 32'hFFFF_FFFE, 0, 0, 0);
    add_row(4, MODE_CLOSEST, FUNC_SEARCH,   0, 32'h8080_8080, 0, 0, 0);
    add_row(4, MODE_CLOSEST, FUNC_SEARCH,   0, 32'hFFFF_FFFF, 0, 0, 0);
    // empty palette in both modes
    add_row(0, MODE_CLOSEST, FUNC_SEARCH,   0, 32'hFFFF_FFFF, 1, 0, 0);
    add_row(0, MODE_EXACT,   FUNC_SEARCH,   0, 32'h0000_0000, 1, 0, 0);
    // a single entry in use
    add_row(1, MODE_CLOSEST, FUNC_SEARCH,   0, 32'hFFFF_FFFF, 1, 1, 0);
    add_row(1, MODE_EXACT,   FUNC_SEARCH,   0, 32'hFFFF_FFFF, 1, 0, 0);
    // equal distance to entries 0 and 1: the first wins
    add_row(4, MODE_CLOSEST, FUNC_WRITE,    0, 32'h00FF_00FF, 0, 0, 0);
    add_row(4, MODE_CLOSEST, FUNC_SEARCH,   0, 32'h80FF_7FFF, 0, 0, 0);
    add_row(2, MODE_EXACT,   FUNC_SEARCH,   0, 32'hFFFF_FFFF, 1, 1, 1);

    foreach (dir_rows[j]) begin
      row = dir_rows[j];
      if (row.cnt != cfg_count || row.mode != cfg_mode)
        set_config(row.cnt, row.mode);
      send_req(row.req, row.typed, row.want);
    end

    // Random phases, each under its own settings, extremes first
    rand_start = items_sent;
    phase = 0;
    while (items_sent - rand_start < RAND_ITEMS) begin
      case (phase)
        0: begin cnt = 256; mode = MODE_EXACT;   end
        1: begin cnt = 511; mode = MODE_CLOSEST; end
        2: begin cnt = 0;   mode = MODE_CLOSEST; end
        3: begin cnt = 300; mode = MODE_EXACT;   end
        4: begin cnt = 1;   mode = MODE_CLOSEST; end
        5: begin cnt = 257; mode = MODE_CLOSEST; end
        default: begin
          r = $urandom_range(0, 99);
          if (r < 85)
            cnt = $urandom_range(0, 16);
          else if (r < 95)
            cnt = $urandom_range(17, 64);
          else
            cnt = $urandom_range(256, 511);
          mode = $urandom_range(0, 1) ? MODE_CLOSEST : MODE_EXACT;
        end
      endcase
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      set_config(cnt, mode);
      n = (cnt > PAL_DEPTH) ? PAL_DEPTH : cnt;

      // write every entry in use that still holds nothing
      for (i = 0; i < n; i++) begin
        if (!pal_written[i]) begin
          req.func = FUNC_WRITE;
          req.idx = i[IDX_W-1:0];
          req.color = rand_color();
          send_req(req, 1'b0, '0);
        end
      end

      n_items = (n > 64) ? $urandom_range(20, 40) : $urandom_range(40, 90);
      repeat (n_items) begin
        req.idx = IDX_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 35) begin
          req.func = FUNC_WRITE;
          if (n > 0 && $urandom_range(0, 1) == 1)
            req.idx = IDX_W'($urandom_range(0, n - 1));
          req.color = rand_color();
        end else begin
          // search: copy of an entry, a near miss of one, or any color
          req.func = FUNC_SEARCH;
          r = $urandom_range(0, 99);
          if (n > 0 && r < 60) begin
            req.color = pal_copy[$urandom_range(0, n - 1)];
            if (r >= 40) begin
              k = $urandom_range(0, 3);
              req.color[CHAN_W*k +: CHAN_W] = req.color[CHAN_W*k +: CHAN_W] +
                                              ($urandom_range(0, 1) ? 8'h01 : 8'hFF);
            end
          end else begin
            req.color = rand_color();
          end
        end
        send_req(req, 1'b0, '0);
      end
      phase++;
    end

    // Wind down: wait for every pending match, then a quiet tail
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_cnt += pending_matches.size();
    if (fail_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
src/pcm_pkg.sv
src/pcm_front.sv
src/pcm_queue.sv
src/pcm_back.sv
src/palette_color_match_unit.sv
verif/palette_color_match_unit_tb.sv
